// ===== hdl/lgts_pkg.sv =====
// Shared types, codes and defaults of the LDA Gibbs token sampler.
`default_nettype none

package lgts_pkg;

  // Parameter defaults
  localparam int DEF_MAX_TOPICS = 64;
  localparam int DEF_MAX_VOCAB  = 4096;
  localparam int DEF_COUNT_BITS = 32;

  // Fixed field widths
  localparam int WEIGHT_BITS = 48;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOPICS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOCAB  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA   = 2'd3;

  // Configuration reset values
  localparam logic [6:0]  RST_TOPICS = 7'd64;
  localparam logic [12:0] RST_VOCAB  = 13'd4096;
  localparam logic [23:0] RST_ALPHA  = 24'd65536;
  localparam logic [23:0] RST_BETA   = 24'd6554;

  typedef enum logic [2:0] {
    CMD_SAMPLE   = 3'd0,
    CMD_WR_DOC   = 3'd1,
    CMD_WR_WORD  = 3'd2,
    CMD_WR_TOTAL = 3'd3,
    CMD_RD_DOC   = 3'd4,
    CMD_RD_WORD  = 3'd5,
    CMD_RD_TOTAL = 3'd6,
    CMD_UNUSED   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_WORD  = 2'd1,
    ERR_TOPIC = 2'd2
  } err_t;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LATCH,
    DP_CHECK,
    DP_TBL_WR,
    DP_TBL_RD,
    DP_TBL_RDATA,
    DP_RM_RD,
    DP_RM_WR,
    DP_K_RD,
    DP_FACT,
    DP_MUL,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_WSTORE,
    DP_TMUL,
    DP_THRSET,
    DP_SCAN_RD,
    DP_SCAN_CHK,
    DP_ADD_RD,
    DP_ADD_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] step;
  } dp_cmd_t;

  typedef struct packed {
    err_t err;
    logic is_sample;
    logic is_write;
    logic is_read;
    logic has_old;
    logic k_last;
    logic div_skip;
    logic div_last;
    logic scan_hit;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/lgts_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none

module lgts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/lgts_ctrl.sv =====
// Controller state machine of the LDA Gibbs token sampler.
`default_nettype none

module lgts_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire lgts_pkg::dp_status_t   status,
  output lgts_pkg::dp_cmd_t           dp_cmd,
  output logic                        busy,
  output logic                        done
);

  import lgts_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_TBL_WR,
    S_TBL_RD,
    S_TBL_RDATA,
    S_RM_RD,
    S_RM_WR,
    S_K_RD,
    S_FACT,
    S_MUL,
    S_DIV_INIT,
    S_DIV_STEP,
    S_WSTORE,
    S_TMUL,
    S_THRSET,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_ADD_RD,
    S_ADD_WR
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] mstep_r, mstep_nxt;
  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  dp_op_t     op;

  // Next state and datapath command
  always_comb begin
    state_nxt = state_r;
    mstep_nxt = mstep_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    op        = DP_NOP;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op        = DP_LATCH;
          state_nxt = S_CHECK;
          busy_nxt  = 1'b1;
        end
      end
      S_CHECK: begin
        op = DP_CHECK;
        if (status.err != ERR_OK) begin
          state_nxt = S_IDLE;
          busy_nxt  = 1'b0;
          done_nxt  = 1'b1;
        end else if (status.is_write) begin
          state_nxt = S_TBL_WR;
        end else if (status.is_read) begin
          state_nxt = S_TBL_RD;
        end else if (status.is_sample) begin
          state_nxt = status.has_old ? S_RM_RD : S_K_RD;
        end else begin
          state_nxt = S_IDLE;
          busy_nxt  = 1'b0;
          done_nxt  = 1'b1;
        end
      end
      S_TBL_WR: begin
        op        = DP_TBL_WR;
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
      end
      S_TBL_RD: begin
        op        = DP_TBL_RD;
        state_nxt = S_TBL_RDATA;
      end
      S_TBL_RDATA: begin
        op        = DP_TBL_RDATA;
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
      end
      S_RM_RD: begin
        op        = DP_RM_RD;
        state_nxt = S_RM_WR;
      end
      S_RM_WR: begin
        op        = DP_RM_WR;
        state_nxt = S_K_RD;
      end
      S_K_RD: begin
        op        = DP_K_RD;
        state_nxt = S_FACT;
      end
      S_FACT: begin
        op        = DP_FACT;
        mstep_nxt = 3'd0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        op = DP_MUL;
        if (mstep_r == 3'd4) begin
          mstep_nxt = 3'd0;
          state_nxt = S_DIV_INIT;
        end else begin
          mstep_nxt = mstep_r + 3'd1;
        end
      end
      S_DIV_INIT: begin
        op        = DP_DIV_INIT;
        state_nxt = status.div_skip ? S_WSTORE : S_DIV_STEP;
      end
      S_DIV_STEP: begin
        op = DP_DIV_STEP;
        if (status.div_last) begin
          state_nxt = S_WSTORE;
        end
      end
      S_WSTORE: begin
        op = DP_WSTORE;
        if (status.k_last) begin
          mstep_nxt = 3'd0;
          state_nxt = S_TMUL;
        end else begin
          state_nxt = S_K_RD;
        end
      end
      S_TMUL: begin
        op = DP_TMUL;
        if (mstep_r == 3'd2) begin
          mstep_nxt = 3'd0;
          state_nxt = S_THRSET;
        end else begin
          mstep_nxt = mstep_r + 3'd1;
        end
      end
      S_THRSET: begin
        op        = DP_THRSET;
        state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        op        = DP_SCAN_RD;
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        op        = DP_SCAN_CHK;
        state_nxt = (status.scan_hit || status.k_last) ? S_ADD_RD : S_SCAN_RD;
      end
      S_ADD_RD: begin
        op        = DP_ADD_RD;
        state_nxt = S_ADD_WR;
      end
      S_ADD_WR: begin
        op        = DP_ADD_WR;
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mstep_r <= 3'd0;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mstep_r <= mstep_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
    end
  end

  assign dp_cmd.op   = op;
  assign dp_cmd.step = mstep_r;
  assign busy        = busy_r;
  assign done        = done_r;

endmodule

`default_nettype wire

// ===== hdl/lgts_datapath.sv =====
// Datapath of the LDA Gibbs token sampler: count tables, weight unit, scan.
`default_nettype none

module lgts_datapath #(
  parameter int MAX_TOPICS = lgts_pkg::DEF_MAX_TOPICS,
  parameter int MAX_VOCAB  = lgts_pkg::DEF_MAX_VOCAB,
  parameter int COUNT_BITS = lgts_pkg::DEF_COUNT_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [lgts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lgts_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [2:0]                      in_command,
  input  wire logic [15:0]                     in_token_index,
  input  wire logic [11:0]                     in_word_id,
  input  wire logic [6:0]                      in_topic,
  input  wire logic [31:0]                     in_random_fraction,
  input  wire logic [31:0]                     in_count_value,
  input  wire logic                            in_end_of_document,
  input  wire lgts_pkg::dp_cmd_t               dp_cmd,
  output lgts_pkg::dp_status_t                 status,
  output logic      [6:0]                      out_new_topic,
  output logic      [15:0]                     out_token_echo,
  output logic      [31:0]                     out_read_count,
  output logic                                 out_document_done,
  output logic      [1:0]                      out_error_code
);

  import lgts_pkg::*;

  localparam int TW  = $clog2(MAX_TOPICS);
  localparam int VW  = $clog2(MAX_VOCAB);
  localparam int WAW = VW + TW;
  localparam int CW  = COUNT_BITS;
  localparam int SW  = WEIGHT_BITS + TW;
  localparam logic [CW-1:0]          CNT_MAX = {CW{1'b1}};
  localparam logic [WEIGHT_BITS-1:0] W_MAX   = {WEIGHT_BITS{1'b1}};

  // Saturating count steps
  function automatic logic [CW-1:0] dec_sat(input logic [CW-1:0] v);
    return (v == '0) ? '0 : v - CW'(1);
  endfunction

  function automatic logic [CW-1:0] inc_sat(input logic [CW-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + CW'(1);
  endfunction

  // count * 2^16 + addend, saturated to 64 bits
  function automatic logic [63:0] q16_factor(input logic [CW-1:0] c, input logic [36:0] add);
    logic [64:0] s;
    s = 65'({c, 16'h0000}) + 65'(add);
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  // Configuration registers
  logic [6:0]  cfg_topics_r;
  logic [12:0] cfg_vocab_r;
  logic [23:0] alpha_r;
  logic [23:0] beta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_topics_r <= RST_TOPICS;
      cfg_vocab_r  <= RST_VOCAB;
      alpha_r      <= RST_ALPHA;
      beta_r       <= RST_BETA;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOPICS: cfg_topics_r <= 7'(cfg_wdata);
        CFG_VOCAB:  cfg_vocab_r  <= 13'(cfg_wdata);
        CFG_ALPHA:  alpha_r      <= cfg_wdata;
        CFG_BETA:   beta_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp configuration to the built range
  logic [6:0]  eff_k;
  logic [12:0] eff_v;

  always_comb begin
    if (cfg_topics_r < 7'd2) begin
      eff_k = 7'd2;
    end else if (32'(cfg_topics_r) > MAX_TOPICS) begin
      eff_k = 7'(MAX_TOPICS);
    end else begin
      eff_k = cfg_topics_r;
    end
    if (cfg_vocab_r == 13'd0) begin
      eff_v = 13'd1;
    end else if (32'(cfg_vocab_r) > MAX_VOCAB) begin
      eff_v = 13'(MAX_VOCAB);
    end else begin
      eff_v = cfg_vocab_r;
    end
  end

  // Item registers
  cmd_t        cmd_r;
  logic [15:0] tok_r;
  logic [11:0] word_r;
  logic [6:0]  topic_r;
  logic [31:0] frac_r;
  logic [31:0] val_r;
  logic        eod_r;

  // Work registers
  logic [36:0]          bsum_r;
  logic [TW-1:0]        k_r;
  logic [63:0]          a_r, b_r, d_r;
  logic [63:0]          prod_r;
  logic [1:0]           psh_r;
  logic [127:0]         acc_r;
  logic [63:0]          rem_r, lo_r, q_r;
  logic [5:0]           dcnt_r;
  logic                 spec_r, spec_max_r;
  logic [SW-1:0]        sum_r, cum_r, thr_r;
  logic [6:0]           new_topic_r;
  logic [31:0]          read_count_r;
  err_t                 err_r;

  // Command decode and checks
  logic is_sample, is_write, is_read, is_doc, is_word, is_total;
  logic topic_hi, word_hi;
  err_t err;

  always_comb begin
    is_sample = (cmd_r == CMD_SAMPLE);
    is_write  = cmd_r inside {CMD_WR_DOC, CMD_WR_WORD, CMD_WR_TOTAL};
    is_read   = cmd_r inside {CMD_RD_DOC, CMD_RD_WORD, CMD_RD_TOTAL};
    is_doc    = cmd_r inside {CMD_WR_DOC, CMD_RD_DOC};
    is_word   = cmd_r inside {CMD_WR_WORD, CMD_RD_WORD};
    is_total  = cmd_r inside {CMD_WR_TOTAL, CMD_RD_TOTAL};
    topic_hi  = (topic_r > eff_k);
    word_hi   = (13'(word_r) >= eff_v);
    err       = ERR_OK;
    if (is_sample) begin
      if (topic_hi) begin
        err = ERR_TOPIC;
      end else if (word_hi) begin
        err = ERR_WORD;
      end
    end else if (is_write || is_read) begin
      if (topic_r == 7'd0 || topic_hi) begin
        err = ERR_TOPIC;
      end else if (is_word && word_hi) begin
        err = ERR_WORD;
      end
    end
  end

  // Table addressing
  logic          use_k;
  logic [TW-1:0] t_old, t_addr;
  logic [WAW-1:0] w_addr;

  assign use_k  = dp_cmd.op inside {DP_K_RD, DP_ADD_RD, DP_ADD_WR};
  assign t_old  = TW'(topic_r - 7'd1);
  assign t_addr = use_k ? k_r : t_old;
  assign w_addr = {VW'(word_r), t_addr};

  // Count table writes
  logic [CW-1:0] doc_q, word_q, tot_q;
  logic [CW-1:0] doc_d, word_d, tot_d, val_sat;
  logic          doc_we, word_we, tot_we;

  assign val_sat = (64'(val_r) > 64'(CNT_MAX)) ? CNT_MAX : CW'(val_r);

  always_comb begin
    doc_we  = 1'b0;
    word_we = 1'b0;
    tot_we  = 1'b0;
    doc_d   = val_sat;
    word_d  = val_sat;
    tot_d   = val_sat;
    case (dp_cmd.op)
      DP_RM_WR: begin
        doc_we  = 1'b1;
        word_we = 1'b1;
        tot_we  = 1'b1;
        doc_d   = dec_sat(doc_q);
        word_d  = dec_sat(word_q);
        tot_d   = dec_sat(tot_q);
      end
      DP_ADD_WR: begin
        doc_we  = 1'b1;
        word_we = 1'b1;
        tot_we  = 1'b1;
        doc_d   = inc_sat(doc_q);
        word_d  = inc_sat(word_q);
        tot_d   = inc_sat(tot_q);
      end
      DP_TBL_WR: begin
        doc_we  = is_doc;
        word_we = is_word;
        tot_we  = is_total;
      end
      default: ;
    endcase
  end

  lgts_ram #(.WIDTH(CW), .DEPTH(MAX_TOPICS)) u_doc_ram (
    .clk   (clk),
    .we    (doc_we),
    .waddr (t_addr),
    .wdata (doc_d),
    .raddr (t_addr),
    .rdata (doc_q)
  );

  lgts_ram #(.WIDTH(CW), .DEPTH(MAX_VOCAB * (2 ** TW))) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (w_addr),
    .wdata (word_d),
    .raddr (w_addr),
    .rdata (word_q)
  );

  lgts_ram #(.WIDTH(CW), .DEPTH(MAX_TOPICS)) u_tot_ram (
    .clk   (clk),
    .we    (tot_we),
    .waddr (t_addr),
    .wdata (tot_d),
    .raddr (t_addr),
    .rdata (tot_q)
  );

  // Weight store
  logic [WEIGHT_BITS-1:0] w_val, w_q;
  logic                   w_we;

  assign w_val = spec_r ? (spec_max_r ? W_MAX : '0)
                        : ((q_r[63:48] != 16'd0) ? W_MAX : q_r[47:0]);
  assign w_we  = (dp_cmd.op == DP_WSTORE);

  lgts_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_TOPICS)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (k_r),
    .wdata (w_val),
    .raddr (k_r),
    .rdata (w_q)
  );

  // Shared 32x32 multiplier, operands picked per partial product
  logic [31:0]  mul_x, mul_y;
  logic [63:0]  mul_p;
  logic [1:0]   mul_sh;
  logic [127:0] acc_add;

  always_comb begin
    mul_x  = 32'd0;
    mul_y  = 32'd0;
    mul_sh = 2'd0;
    case (dp_cmd.op)
      DP_MUL: begin
        case (dp_cmd.step)
          3'd0: begin
            mul_x  = a_r[31:0];
            mul_y  = b_r[31:0];
            mul_sh = 2'd0;
          end
          3'd1: begin
            mul_x  = a_r[31:0];
            mul_y  = b_r[63:32];
            mul_sh = 2'd1;
          end
          3'd2: begin
            mul_x  = a_r[63:32];
            mul_y  = b_r[31:0];
            mul_sh = 2'd1;
          end
          default: begin
            mul_x  = a_r[63:32];
            mul_y  = b_r[63:32];
            mul_sh = 2'd2;
          end
        endcase
      end
      DP_TMUL: begin
        mul_y = frac_r;
        if (dp_cmd.step == 3'd0) begin
          mul_x  = 32'(sum_r);
          mul_sh = 2'd0;
        end else begin
          mul_x  = 32'(sum_r >> 32);
          mul_sh = 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign mul_p = 64'(mul_x) * 64'(mul_y);

  always_comb begin
    case (psh_r)
      2'd0:    acc_add = acc_r + {64'd0, prod_r};
      2'd1:    acc_add = acc_r + {32'd0, prod_r, 32'd0};
      default: acc_add = acc_r + {prod_r, 64'd0};
    endcase
  end

  // Divider and scan conditions
  logic          div_skip;
  logic [64:0]   rr;
  logic          rr_ge;
  logic [SW-1:0] cum_nxt;
  logic          k_last;

  assign div_skip = (d_r == 64'd0) || (acc_r[127:64] >= d_r);
  assign rr       = {rem_r, lo_r[63]};
  assign rr_ge    = (rr >= {1'b0, d_r});
  assign cum_nxt  = cum_r + SW'(w_q);
  assign k_last   = (k_r == TW'(eff_k - 7'd1));

  // Datapath registers
  always_ff @(posedge clk) begin
    case (dp_cmd.op)
      DP_LATCH: begin
        cmd_r        <= cmd_t'(in_command);
        tok_r        <= in_token_index;
        word_r       <= in_word_id;
        topic_r      <= in_topic;
        frac_r       <= in_random_fraction;
        val_r        <= in_count_value;
        eod_r        <= in_end_of_document;
        new_topic_r  <= 7'd0;
        read_count_r <= 32'd0;
        err_r        <= ERR_OK;
      end
      DP_CHECK: begin
        err_r  <= err;
        bsum_r <= 37'(eff_v) * 37'(beta_r);
        k_r    <= '0;
        sum_r  <= '0;
      end
      DP_TBL_RDATA: begin
        read_count_r <= (64'(is_doc ? doc_q : (is_word ? word_q : tot_q)) > 64'(32'hFFFF_FFFF))
                        ? 32'hFFFF_FFFF
                        : 32'(is_doc ? doc_q : (is_word ? word_q : tot_q));
      end
      DP_FACT: begin
        a_r <= q16_factor(doc_q, 37'(alpha_r));
        b_r <= q16_factor(word_q, 37'(beta_r));
        d_r <= q16_factor(tot_q, bsum_r);
      end
      DP_MUL: begin
        acc_r <= (dp_cmd.step == 3'd0) ? 128'd0 : acc_add;
        if (dp_cmd.step < 3'd4) begin
          prod_r <= mul_p;
          psh_r  <= mul_sh;
        end
      end
      DP_TMUL: begin
        acc_r <= (dp_cmd.step == 3'd0) ? 128'd0 : acc_add;
        if (dp_cmd.step < 3'd2) begin
          prod_r <= mul_p;
          psh_r  <= mul_sh;
        end
      end
      DP_DIV_INIT: begin
        rem_r      <= acc_r[127:64];
        lo_r       <= acc_r[63:0];
        q_r        <= 64'd0;
        dcnt_r     <= 6'd0;
        spec_r     <= div_skip;
        spec_max_r <= (d_r == 64'd0) ? (acc_r != 128'd0) : 1'b1;
      end
      DP_DIV_STEP: begin
        rem_r  <= rr_ge ? 64'(rr - {1'b0, d_r}) : rr[63:0];
        lo_r   <= {lo_r[62:0], 1'b0};
        q_r    <= {q_r[62:0], rr_ge};
        dcnt_r <= dcnt_r + 6'd1;
      end
      DP_WSTORE: begin
        sum_r <= sum_r + SW'(w_val);
        if (!k_last) begin
          k_r <= k_r + TW'(1);
        end
      end
      DP_THRSET: begin
        thr_r <= acc_r[32 +: SW];
        k_r   <= '0;
        cum_r <= '0;
      end
      DP_SCAN_CHK: begin
        cum_r <= cum_nxt;
        if (!(thr_r < cum_nxt) && !k_last) begin
          k_r <= k_r + TW'(1);
        end
      end
      DP_ADD_WR: begin
        new_topic_r <= 7'(k_r) + 7'd1;
      end
      default: ;
    endcase
  end

  // Status toward the controller
  assign status.err       = err;
  assign status.is_sample = is_sample;
  assign status.is_write  = is_write;
  assign status.is_read   = is_read;
  assign status.has_old   = (topic_r != 7'd0);
  assign status.k_last    = k_last;
  assign status.div_skip  = div_skip;
  assign status.div_last  = (dcnt_r == 6'd63);
  assign status.scan_hit  = (thr_r < cum_nxt);

  // Result fields
  assign out_new_topic     = new_topic_r;
  assign out_token_echo    = tok_r;
  assign out_read_count    = read_count_r;
  assign out_document_done = eod_r;
  assign out_error_code    = err_r;

endmodule

`default_nettype wire

// ===== hdl/lda_gibbs_token_sampler_unit.sv =====
// Top level of the LDA collapsed Gibbs token sampler.
// Accept to out_valid: a table write passes S_CHECK, S_TBL_WR; a read S_CHECK, S_TBL_RD,
// S_TBL_RDATA; errors and the unused command S_CHECK alone. Sample time grows with K topics, the
// pick at topic J and a held old topic, mostly from the bit-serial divider (64 steps per weight).
// The divider is skipped on zero or overflow. One item at a time: start is taken again in the cycle out_valid is high.
// Synchronous active-low reset clears control and configuration; count tables are not cleared.
`default_nettype none

module lda_gibbs_token_sampler_unit #(
  parameter int MAX_TOPICS = lgts_pkg::DEF_MAX_TOPICS,
  parameter int MAX_VOCAB  = lgts_pkg::DEF_MAX_VOCAB,
  parameter int COUNT_BITS = lgts_pkg::DEF_COUNT_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [lgts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lgts_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [2:0]                      in_command,
  input  wire logic [15:0]                     in_token_index,
  input  wire logic [11:0]                     in_word_id,
  input  wire logic [6:0]                      in_topic,
  input  wire logic [31:0]                     in_random_fraction,
  input  wire logic [31:0]                     in_count_value,
  input  wire logic                            in_end_of_document,
  output logic                                 out_valid,
  output logic      [6:0]                      out_new_topic,
  output logic      [15:0]                     out_token_echo,
  output logic      [31:0]                     out_read_count,
  output logic                                 out_document_done,
  output logic      [1:0]                      out_error_code
);

  import lgts_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t status;

  lgts_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .dp_cmd (dp_cmd),
    .busy   (busy),
    .done   (out_valid)
  );

  lgts_datapath #(
    .MAX_TOPICS (MAX_TOPICS),
    .MAX_VOCAB  (MAX_VOCAB),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_command         (in_command),
    .in_token_index     (in_token_index),
    .in_word_id         (in_word_id),
    .in_topic           (in_topic),
    .in_random_fraction (in_random_fraction),
    .in_count_value     (in_count_value),
    .in_end_of_document (in_end_of_document),
    .dp_cmd             (dp_cmd),
    .status             (status),
    .out_new_topic      (out_new_topic),
    .out_token_echo     (out_token_echo),
    .out_read_count     (out_read_count),
    .out_document_done  (out_document_done),
    .out_error_code     (out_error_code)
  );

  // Result strobe only once the unit is free again
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // An accepted transfer makes the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not start work");

  // One strobe per item
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe repeated");

  // An errored item carries no topic and no count
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code != ERR_OK) |-> (out_new_topic == 7'd0 && out_read_count == 32'd0))
    else $error("errored result carries data");

endmodule

`default_nettype wire

// ===== tb/lda_gibbs_token_sampler_unit_tb.sv =====
// Self-checking testbench for the LDA Gibbs token sampler: queued stimulus, clocked driver and monitor.
`default_nettype none

module lda_gibbs_token_sampler_unit_tb;
  import lgts_pkg::*;

  localparam logic [47:0] WEIGHT_SAT = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] COUNT_SAT  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {JOB_TOKEN, JOB_CFG, JOB_DRAIN} job_kind_t;

  typedef struct {
    job_kind_t   kind;
    cmd_t        cmd;
    logic [15:0] token;
    logic [11:0] word;
    logic [6:0]  topic;
    logic [31:0] frac;
    logic [31:0] value;
    logic        eod;
    logic [1:0]  reg_idx;
    logic [23:0] reg_val;
  } job_t;

  typedef struct {
    logic [6:0]  new_topic;
    logic [15:0] token;
    logic [31:0] count;
    logic        done;
    err_t        err;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_command = '0;
  logic [15:0] in_token_index = '0;
  logic [11:0] in_word_id = '0;
  logic [6:0] in_topic = '0;
  logic [31:0] in_random_fraction = '0;
  logic [31:0] in_count_value = '0;
  logic in_end_of_document = 1'b0;
  logic out_valid;
  logic [6:0] out_new_topic;
  logic [15:0] out_token_echo;
  logic [31:0] out_read_count;
  logic out_document_done;
  logic [1:0] out_error_code;

  lda_gibbs_token_sampler_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy),
    .in_command(in_command), .in_token_index(in_token_index), .in_word_id(in_word_id),
    .in_topic(in_topic), .in_random_fraction(in_random_fraction),
    .in_count_value(in_count_value), .in_end_of_document(in_end_of_document),
    .out_valid(out_valid), .out_new_topic(out_new_topic), .out_token_echo(out_token_echo),
    .out_read_count(out_read_count), .out_document_done(out_document_done),
    .out_error_code(out_error_code)
  );

  // Shadow copy of the sampler state
  localparam int MAX_TOPICS_TB = DEF_MAX_TOPICS;
  logic [31:0] doc_cnt [MAX_TOPICS_TB];
  logic [31:0] total_cnt [MAX_TOPICS_TB];
  logic [31:0] word_cnt [int];
  logic [6:0]  sh_topics = RST_TOPICS;
  logic [12:0] sh_vocab = RST_VOCAB;
  logic [23:0] sh_alpha = RST_ALPHA;
  logic [23:0] sh_beta = RST_BETA;

  job_t    pending_jobs[$];
  answer_t expected_answers[$];
  job_t    cur_job;
  int      hold_cycles = 0;
  int      transfers = 0;
  int      mismatches = 0;
  int      n_samples = 0, n_writes = 0, n_reads = 0, n_errors = 0, n_answers = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("FAIL lda_gibbs_token_sampler_unit");
    $finish;
  end

  function automatic int eff_topics(logic [6:0] k);
    return (k < 2) ? 2 : (k > DEF_MAX_TOPICS) ? DEF_MAX_TOPICS : int'(k);
  endfunction

  function automatic int eff_vocab(logic [12:0] v);
    return (v < 1) ? 1 : (v > DEF_MAX_VOCAB) ? DEF_MAX_VOCAB : int'(v);
  endfunction

  function automatic logic [47:0] topic_weight(logic [63:0] a, logic [63:0] b, logic [63:0] d);
    logic [127:0] prod;
    logic [127:0] quo;
    prod = {64'd0, a} * {64'd0, b};
    if (d == 0) return (prod != 0) ? WEIGHT_SAT : 48'd0;
    quo = prod / {64'd0, d};
    return (quo > {80'd0, WEIGHT_SAT}) ? WEIGHT_SAT : quo[47:0];
  endfunction

  function automatic logic [31:0] dec_sat(logic [31:0] v);
    return (v == 0) ? 32'd0 : v - 1;
  endfunction

  function automatic logic [31:0] inc_sat(logic [31:0] v);
    return (v == COUNT_SAT) ? COUNT_SAT : v + 1;
  endfunction

  function automatic logic [31:0] word_entry(int w, int t);
    return word_cnt.exists(w * DEF_MAX_TOPICS + t) ? word_cnt[w * DEF_MAX_TOPICS + t] : 32'd0;
  endfunction

  // Resample one token against the shadow tables and return the 1-based topic
  function automatic logic [6:0] resample(int w, int old_topic, logic [31:0] frac, int k);
    logic [47:0]  wt [DEF_MAX_TOPICS];
    logic [63:0]  sum, cum, bsum, fa, fb, fd;
    logic [127:0] thr;
    int pick, o;
    bsum = 64'(eff_vocab(sh_vocab)) * 64'(sh_beta);
    if (old_topic > 0) begin
      o = old_topic - 1;
      doc_cnt[o] = dec_sat(doc_cnt[o]);
      word_cnt[w * DEF_MAX_TOPICS + o] = dec_sat(word_entry(w, o));
      total_cnt[o] = dec_sat(total_cnt[o]);
    end
    sum = 0;
    for (int i = 0; i < k; i++) begin
      fa = {16'd0, doc_cnt[i], 16'd0} + 64'(sh_alpha);
      fb = {16'd0, word_entry(w, i), 16'd0} + 64'(sh_beta);
      fd = {16'd0, total_cnt[i], 16'd0} + bsum;
      wt[i] = topic_weight(fa, fb, fd);
      sum += 64'(wt[i]);
    end
    thr = ({64'd0, sum} * {96'd0, frac}) >> 32;
    pick = k - 1;
    cum = 0;
    for (int i = 0; i < k; i++) begin
      cum += 64'(wt[i]);
      if (thr < {64'd0, cum}) begin
        pick = i;
        break;
      end
    end
    doc_cnt[pick] = inc_sat(doc_cnt[pick]);
    word_cnt[w * DEF_MAX_TOPICS + pick] = inc_sat(word_entry(w, pick));
    total_cnt[pick] = inc_sat(total_cnt[pick]);
    return 7'(pick + 1);
  endfunction

  // Work out the answer of one transferred token and queue it
  task automatic predict_answer(job_t j);
    answer_t a;
    int k, v, o;
    logic is_word;
    k = eff_topics(sh_topics);
    v = eff_vocab(sh_vocab);
    a.new_topic = '0;
    a.token = j.token;
    a.count = '0;
    a.done = j.eod;
    a.err = ERR_OK;
    is_word = (j.cmd == CMD_WR_WORD) || (j.cmd == CMD_RD_WORD);
    o = int'(j.topic) - 1;
    if (j.cmd == CMD_SAMPLE) begin
      if (j.topic > k) a.err = ERR_TOPIC;
      else if (j.word >= v) a.err = ERR_WORD;
      else a.new_topic = resample(int'(j.word), int'(j.topic), j.frac, k);
    end else if (j.cmd != CMD_UNUSED) begin
      if (j.topic == 0 || j.topic > k) a.err = ERR_TOPIC;
      else if (is_word && j.word >= v) a.err = ERR_WORD;
      else begin
        case (j.cmd)
          CMD_WR_DOC:   doc_cnt[o] = j.value;
          CMD_WR_WORD:  word_cnt[int'(j.word) * DEF_MAX_TOPICS + o] = j.value;
          CMD_WR_TOTAL: total_cnt[o] = j.value;
          CMD_RD_DOC:   a.count = doc_cnt[o];
          CMD_RD_WORD:  a.count = word_entry(int'(j.word), o);
          CMD_RD_TOTAL: a.count = total_cnt[o];
          default: ;
        endcase
      end
    end
    expected_answers.push_back(a);
  endtask

  task automatic report(string field, logic [31:0] want, logic [31:0] got);
    $display("mismatch %0d: %s expected %0h got %0h (token %0h)",
             mismatches, field, want, got, out_token_echo);
    mismatches++;
  endtask

  // Driver: present queued tokens, apply register writes only while idle
  always @(posedge clk) begin
    logic nx_start, nx_we, took;
    int idle_pct;
    nx_start = start;
    nx_we = 1'b0;
    took = start && !busy;
    idle_pct = (transfers < 200) ? 9 : (transfers < 400) ? 47 : 0;
    if (rst_n) begin
      if (took) begin
        predict_answer(cur_job);
        transfers++;
        nx_start = 1'b0;
      end
      if (!nx_start) begin
        if (hold_cycles > 0) begin
          hold_cycles--;
        end else if (pending_jobs.size() > 0) begin
          case (pending_jobs[0].kind)
            JOB_TOKEN: begin
              if ($urandom_range(99) >= idle_pct) begin
                cur_job = pending_jobs.pop_front();
                in_command <= cur_job.cmd;
                in_token_index <= cur_job.token;
                in_word_id <= cur_job.word;
                in_topic <= cur_job.topic;
                in_random_fraction <= cur_job.frac;
                in_count_value <= cur_job.value;
                in_end_of_document <= cur_job.eod;
                nx_start = 1'b1;
              end
            end
            JOB_CFG: begin
              if (expected_answers.size() == 0 && !took) begin
                cur_job = pending_jobs.pop_front();
                nx_we = 1'b1;
                cfg_index <= cur_job.reg_idx;
                cfg_wdata <= cur_job.reg_val;
                case (cur_job.reg_idx)
                  CFG_TOPICS: sh_topics = cur_job.reg_val[6:0];
                  CFG_VOCAB:  sh_vocab = cur_job.reg_val[12:0];
                  CFG_ALPHA:  sh_alpha = cur_job.reg_val;
                  default:    sh_beta = cur_job.reg_val;
                endcase
                hold_cycles = 3;
              end
            end
            default: begin
              if (expected_answers.size() == 0) void'(pending_jobs.pop_front());
            end
          endcase
        end
      end
    end
    start <= nx_start;
    cfg_we <= nx_we;
  end

  // Monitor: compare every strobed answer with the oldest expectation
  always @(posedge clk) begin
    answer_t a;
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        report("unexpected answer", 32'd0, 32'(out_token_echo));
      end else begin
        a = expected_answers.pop_front();
        n_answers++;
        if (a.err != ERR_OK) n_errors++;
        if (out_new_topic !== a.new_topic) report("new_topic", 32'(a.new_topic), 32'(out_new_topic));
        if (out_token_echo !== a.token) report("token_echo", 32'(a.token), 32'(out_token_echo));
        if (out_read_count !== a.count) report("read_count", a.count, out_read_count);
        if (out_document_done !== a.done) report("document_done", 32'(a.done), 32'(out_document_done));
        if (out_error_code !== a.err) report("error_code", 32'(a.err), 32'(out_error_code));
      end
    end
  end

  function automatic job_t token_job(cmd_t c, int w, int t, logic [31:0] f, logic [31:0] v);
    job_t j;
    j.kind = JOB_TOKEN;
    j.cmd = c;
    j.token = 16'($urandom);
    j.word = 12'(w);
    j.topic = 7'(t);
    j.frac = f;
    j.value = v;
    j.eod = 1'($urandom);
    j.reg_idx = '0;
    j.reg_val = '0;
    return j;
  endfunction

  task automatic push_token(cmd_t c, int w, int t, logic [31:0] f, logic [31:0] v);
    pending_jobs.push_back(token_job(c, w, t, f, v));
    case (c)
      CMD_SAMPLE: n_samples++;
      CMD_WR_DOC, CMD_WR_WORD, CMD_WR_TOTAL: n_writes++;
      CMD_RD_DOC, CMD_RD_WORD, CMD_RD_TOTAL: n_reads++;
      default: ;
    endcase
  endtask

  task automatic push_cfg(logic [1:0] idx, logic [23:0] val);
    job_t j;
    j = token_job(CMD_UNUSED, 0, 0, 0, 0);
    j.kind = JOB_CFG;
    j.reg_idx = idx;
    j.reg_val = val;
    pending_jobs.push_back(j);
  endtask

  task automatic push_drain();
    job_t j;
    j = token_job(CMD_UNUSED, 0, 0, 0, 0);
    j.kind = JOB_DRAIN;
    pending_jobs.push_back(j);
  endtask

  function automatic logic [31:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 32'($urandom_range(6));
    if (r < 85) return COUNT_SAT - 32'($urandom_range(2));
    return 32'($urandom);
  endfunction

  function automatic logic [31:0] pick_frac();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    return 32'($urandom);
  endfunction

  // One settings phase: drain, write all four registers, seed the tables, then random tokens
  task automatic run_phase(logic [6:0] k_reg, logic [12:0] v_reg, logic [23:0] a_reg,
                           logic [23:0] b_reg, int n_words, int n_tokens);
    int k, v, w, r, c;
    int words[$];
    k = eff_topics(k_reg);
    v = eff_vocab(v_reg);
    push_drain();
    push_cfg(CFG_TOPICS, 24'(k_reg));
    push_cfg(CFG_VOCAB, 24'(v_reg));
    push_cfg(CFG_ALPHA, a_reg);
    push_cfg(CFG_BETA, b_reg);
    if (v - 1 >= 0) words.push_back(v - 1);
    for (int i = 1; i < n_words && i < v; i++) words.push_back($urandom_range(v - 1));
    for (int t = 1; t <= k; t++) begin
      push_token(CMD_WR_DOC, $urandom_range(4095), t, pick_frac(), pick_count());
      push_token(CMD_WR_TOTAL, $urandom_range(4095), t, pick_frac(), pick_count());
      foreach (words[i]) push_token(CMD_WR_WORD, words[i], t, pick_frac(), pick_count());
    end
    for (int n = 0; n < n_tokens; n++) begin
      w = words[$urandom_range(words.size() - 1)];
      r = $urandom_range(99);
      if (r < 55) begin
        push_token(CMD_SAMPLE, w, $urandom_range(k), pick_frac(), 32'($urandom));
      end else if (r < 80) begin
        c = $urandom_range(int'(CMD_RD_TOTAL), int'(CMD_WR_DOC));
        push_token(cmd_t'(c), w, $urandom_range(k, 1), pick_frac(),
                   (c <= int'(CMD_WR_TOTAL)) ? pick_count() : 32'($urandom));
      end else if (r < 88) begin
        // bad topic: above K, or zero (an error for every command but a sample)
        push_token(cmd_t'($urandom_range(6)), w,
                   ($urandom_range(1) && k < 127) ? $urandom_range(127, k + 1) : 0,
                   pick_frac(), 32'($urandom));
      end else if (r < 95 && v < 4096) begin
        // word past the vocabulary
        push_token(($urandom_range(1)) ? CMD_SAMPLE : CMD_RD_WORD, $urandom_range(4095, v),
                   $urandom_range(k, 1), pick_frac(), 32'($urandom));
      end else begin
        push_token(CMD_UNUSED, $urandom_range(4095), $urandom_range(127), pick_frac(),
                   32'($urandom));
      end
      // occasionally let everything settle before the next token
      if ($urandom_range(49) == 0) push_drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: small table, every command and the corner cases
    run_phase(7'd3, 13'd5, RST_ALPHA, RST_BETA, 2, 0);
    push_token(CMD_WR_DOC, 0, 1, 0, COUNT_SAT);
    push_token(CMD_RD_DOC, 0, 1, 0, 0);
    push_token(CMD_WR_WORD, 4, 3, 0, 32'd0);
    push_token(CMD_RD_WORD, 4, 3, 0, 0);
    push_token(CMD_WR_TOTAL, 0, 2, 0, 32'd0);
    push_token(CMD_RD_TOTAL, 0, 2, 0, 0);
    push_token(CMD_SAMPLE, 4, 0, 32'd0, 0);
    push_token(CMD_SAMPLE, 4, 3, 32'hFFFF_FFFF, 0);
    push_token(CMD_SAMPLE, 4, 2, 32'h8000_0000, 0);
    push_token(CMD_SAMPLE, 4, 4, 0, 0);
    push_token(CMD_SAMPLE, 5, 1, 0, 0);
    push_token(CMD_SAMPLE, 4095, 1, 0, 0);
    push_token(CMD_RD_DOC, 0, 0, 0, 0);
    push_token(CMD_WR_TOTAL, 0, 127, 0, 32'hFFFF_FFFF);
    push_token(CMD_RD_WORD, 5, 1, 0, 0);
    push_token(CMD_UNUSED, 4095, 127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_token(CMD_RD_DOC, 0, 1, 0, 0);
    push_token(CMD_RD_TOTAL, 0, 2, 0, 0);
    push_drain();

    // Zero priors give zero denominators; register extremes act as clamps
    run_phase(7'd2, 13'd1, 24'd0, 24'd0, 1, 40);
    run_phase(7'd1, 13'd0, 24'hFF_FFFF, 24'hFF_FFFF, 1, 40);
    run_phase(7'd4, 13'd4096, RST_ALPHA, RST_BETA, 3, 40);
    run_phase(7'd8, 13'd8191, 24'($urandom), 24'($urandom), 3, 40);
    run_phase(7'd100, 13'($urandom_range(4096, 2)), 24'($urandom), 24'($urandom_range(9000)),
              1, 40);
    for (int p = 0; p < 2; p++)
      run_phase(7'($urandom_range(12, 2)), 13'($urandom_range(4096, 1)),
                24'($urandom_range(300000)), 24'($urandom_range(30000)), 2, 40);
    push_drain();

    while (pending_jobs.size() > 0 || start || expected_answers.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d answers: %0d samples, %0d table writes, %0d reads, %0d errors",
             n_answers, n_samples, n_writes, n_reads, n_errors);
    $display("register settings spanned 1..100 topics, vocab 0..8191, zero and full priors");
    if (mismatches == 0 && expected_answers.size() == 0)
      $display("PASS lda_gibbs_token_sampler_unit");
    else
      $display("FAIL lda_gibbs_token_sampler_unit");
    $finish;
  end

endmodule

`default_nettype wire
